/* rtl/sfd_pkg.sv */
package sfd_pkg;

  // Sample and line geometry. LINE_DEPTH must be a power of two.
  localparam int SAMPLE_W   = 24;
  localparam int LINE_DEPTH = 131072;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int FRAME_W    = 2 * SAMPLE_W;

  // Configuration register widths.
  localparam int DELAY_W    = 17;
  localparam int FB_W       = 16;
  localparam int MIX_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Q0.16 feedback gain and Q1.16 mix gain format.
  localparam int FRAC_W     = 16;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);
  localparam int FB_MAX     = 62259;
  localparam int UNITY      = 1 << FRAC_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY    = 2'd0,
    CFG_FEEDBACK = 2'd1,
    CFG_WET_MIX  = 2'd2
  } cfg_idx_e;

  // Per-transaction control handed from the top level to each channel lane.
  typedef struct packed {
    logic accept;    // a new frame enters the read stage
    logic mul_load;  // the read-stage frame moves into the product stage
    logic out_load;  // the product-stage frame moves into the output register
    logic use_fwd;   // delayed sample comes from the frame written just before
    logic use_mem;   // delayed sample slot has been written since reset
  } lane_ctrl_t;

endpackage

/* rtl/sfd_lane.sv */
module sfd_lane (
  input  logic                                  clk_i,
  input  sfd_pkg::lane_ctrl_t                   ctrl_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0]   x_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0]   line_i,
  input  logic [sfd_pkg::FB_W-1:0]              fb_i,
  input  logic [sfd_pkg::MIX_W-1:0]             wet_i,
  input  logic [sfd_pkg::MIX_W-1:0]             dry_i,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]   wr_data_o,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]   y_o
);

  localparam int SW     = sfd_pkg::SAMPLE_W;
  localparam int PROD_W = SW + sfd_pkg::MIX_W + 1;
  localparam int ACC_W  = PROD_W - sfd_pkg::FRAC_W;
  localparam logic signed [PROD_W-1:0] Rnd = PROD_W'(sfd_pkg::ROUND_HALF);

  function automatic logic signed [SW-1:0] sat_sample(input logic signed [ACC_W-1:0] v);
    logic signed [SW-1:0] r;
    if (!v[ACC_W-1] && (|v[ACC_W-2:SW-1])) begin
      r = {1'b0, {(SW-1){1'b1}}};
    end else if (v[ACC_W-1] && !(&v[ACC_W-2:SW-1])) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  logic signed [SW-1:0]     x_q;
  logic signed [SW-1:0]     fwd_q;
  logic signed [SW-1:0]     dl;
  logic signed [PROD_W-1:0] fb_prod;
  logic signed [PROD_W-1:0] fb_rnd;
  logic signed [ACC_W-1:0]  fb_sum;
  logic signed [PROD_W-1:0] p_dry_d, p_dry_q;
  logic signed [PROD_W-1:0] p_wet_d, p_wet_q;
  logic signed [PROD_W-1:0] mix_rnd;
  logic signed [SW-1:0]     y_d, y_q;

  // The frame written by the previous transaction is not yet visible in the
  // line memory read, so its write data is kept here for a short delay; a slot never written reads as zero.
  always_comb begin
    priority if (ctrl_i.use_fwd) begin
      dl = fwd_q;
    end else if (ctrl_i.use_mem) begin
      dl = line_i;
    end else begin
      dl = '0;
    end
  end

  always_comb begin
    fb_prod   = dl * $signed({1'b0, fb_i});
    fb_rnd    = fb_prod + Rnd;
    fb_sum    = ACC_W'(x_q) + $signed(fb_rnd[PROD_W-1:sfd_pkg::FRAC_W]);
    wr_data_o = sat_sample(fb_sum);
    p_dry_d   = x_q * $signed({1'b0, dry_i});
    p_wet_d   = dl * $signed({1'b0, wet_i});
  end

  always_comb begin
    mix_rnd = p_dry_q + p_wet_q + Rnd;
    y_d     = sat_sample($signed(mix_rnd[PROD_W-1:sfd_pkg::FRAC_W]));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      x_q   <= x_i;
      fwd_q <= wr_data_o;
    end
    if (ctrl_i.mul_load) begin
      p_dry_q <= p_dry_d;
      p_wet_q <= p_wet_d;
    end
    if (ctrl_i.out_load) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

/* rtl/stereo_feedback_delay_core.sv */
// Stereo feedback echo with dry/wet mix, one stereo frame per transaction.
// Input channel: in_valid_i/in_ready_o with in_left_i and in_right_i (signed
// Q1.23). Output channel: out_valid_o/out_ready_i with out_left_o and
// out_right_o. Configuration channel: cfg_valid_i/cfg_ready_o with a register
// index (0 delay_frames, 1 feedback_gain, 2 wet_mix) and data; it is always
// ready and should be written only while no frame is in flight.
// An accepted frame moves through the read stage, the product stage and the
// output register, which drives out_valid_o. One frame is accepted every
// cycle while the receiver keeps up; the line memory has one write and one
// read port, and a frame whose delayed sample was written by the frame just
// ahead of it takes that sample from a forwarding register.
// When the receiver stalls, the three pipeline stages fill and in_ready_o
// drops only once every stage holds a frame; nothing is dropped.
// Reset returns the registers to delay 48, feedback 0 and mix one half, and
// the write pointer to zero. The line store reads as silence at once after
// reset: a slot counts as written only once the pointer has passed it, so
// no clearing pass is needed.
module stereo_feedback_delay_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] in_left_i,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0] in_right_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] out_left_o,
  output logic signed [sfd_pkg::SAMPLE_W-1:0] out_right_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sfd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int SW = sfd_pkg::SAMPLE_W;
  localparam int AW = sfd_pkg::ADDR_W;

  logic [sfd_pkg::DELAY_W-1:0] delay_q;
  logic [sfd_pkg::FB_W-1:0]    fb_q;
  logic [sfd_pkg::MIX_W-1:0]   wet_q;
  logic [sfd_pkg::MIX_W-1:0]   dry_q;

  logic [AW-1:0] wp_q;
  logic          wrap_q;
  logic [AW-1:0] rd_wp_q;
  logic          rd_valid_q, mul_valid_q, out_valid_q;
  logic          rd_hit_q, rd_mem_q;

  logic [AW-1:0] delay_eff;
  logic [AW-1:0] rd_addr;
  logic          out_en, mul_en, rd_en;
  logic          in_fire, rd_fire, mul_fire;

  logic [sfd_pkg::FRAME_W-1:0] line_mem [sfd_pkg::LINE_DEPTH];
  logic [sfd_pkg::FRAME_W-1:0] line_rd_q;
  logic [sfd_pkg::FRAME_W-1:0] line_wr;

  sfd_pkg::lane_ctrl_t lane_ctrl;
  logic signed [SW-1:0] wr_left, wr_right;

  // Configuration writes; gains are clamped as they are stored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= sfd_pkg::DELAY_W'(48);
      fb_q    <= '0;
      wet_q   <= sfd_pkg::MIX_W'(sfd_pkg::UNITY / 2);
      dry_q   <= sfd_pkg::MIX_W'(sfd_pkg::UNITY / 2);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfd_pkg::CFG_DELAY: begin
          delay_q <= cfg_data_i[sfd_pkg::DELAY_W-1:0];
        end
        sfd_pkg::CFG_FEEDBACK: begin
          if (cfg_data_i[sfd_pkg::FB_W-1:0] > sfd_pkg::FB_W'(sfd_pkg::FB_MAX)) begin
            fb_q <= sfd_pkg::FB_W'(sfd_pkg::FB_MAX);
          end else begin
            fb_q <= cfg_data_i[sfd_pkg::FB_W-1:0];
          end
        end
        sfd_pkg::CFG_WET_MIX: begin
          if (cfg_data_i[sfd_pkg::MIX_W-1:0] > sfd_pkg::MIX_W'(sfd_pkg::UNITY)) begin
            wet_q <= sfd_pkg::MIX_W'(sfd_pkg::UNITY);
            dry_q <= '0;
          end else begin
            wet_q <= cfg_data_i[sfd_pkg::MIX_W-1:0];
            dry_q <= sfd_pkg::MIX_W'(sfd_pkg::UNITY) - cfg_data_i[sfd_pkg::MIX_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stage enables: each stage moves when the stage after it is free.
  assign out_en     = !out_valid_q || out_ready_i;
  assign mul_en     = !mul_valid_q || out_en;
  assign rd_en      = !rd_valid_q || mul_en;
  assign in_ready_o = rd_en;
  assign in_fire    = in_valid_i && rd_en;
  assign rd_fire    = rd_valid_q && mul_en;
  assign mul_fire   = mul_valid_q && out_en;

  always_comb begin
    if (delay_q > sfd_pkg::DELAY_W'(sfd_pkg::LINE_DEPTH - 1)) begin
      delay_eff = AW'(sfd_pkg::LINE_DEPTH - 1);
    end else begin
      delay_eff = AW'(delay_q);
    end
    rd_addr = wp_q - delay_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      wrap_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      rd_hit_q    <= 1'b0;
      rd_mem_q    <= 1'b0;
      rd_wp_q     <= '0;
    end else begin
      if (in_fire) begin
        wp_q    <= wp_q + 1'b1;
        rd_wp_q <= wp_q;
        if (wp_q == AW'(sfd_pkg::LINE_DEPTH - 1)) begin
          wrap_q <= 1'b1;
        end
        // The frame leaving the read stage writes at this same edge.
        rd_hit_q <= rd_valid_q && (rd_wp_q == rd_addr);
        rd_mem_q <= wrap_q || (rd_addr < wp_q);
      end
      if (rd_en) begin
        rd_valid_q <= in_fire;
      end
      if (mul_en) begin
        mul_valid_q <= rd_valid_q;
      end
      if (out_en) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  assign line_wr = {wr_left, wr_right};

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      line_mem[rd_wp_q] <= line_wr;
    end
    if (in_fire) begin
      line_rd_q <= line_mem[rd_addr];
    end
  end

  always_comb begin
    lane_ctrl.accept   = in_fire;
    lane_ctrl.mul_load = rd_fire;
    lane_ctrl.out_load = mul_fire;
    lane_ctrl.use_fwd  = rd_hit_q;
    lane_ctrl.use_mem  = rd_mem_q;
  end

  sfd_lane u_lane_left (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .x_i       (in_left_i),
    .line_i    ($signed(line_rd_q[sfd_pkg::FRAME_W-1:SW])),
    .fb_i      (fb_q),
    .wet_i     (wet_q),
    .dry_i     (dry_q),
    .wr_data_o (wr_left),
    .y_o       (out_left_o)
  );

  sfd_lane u_lane_right (
    .clk_i     (clk_i),
    .ctrl_i    (lane_ctrl),
    .x_i       (in_right_i),
    .line_i    ($signed(line_rd_q[SW-1:0])),
    .fb_i      (fb_q),
    .wet_i     (wet_q),
    .dry_i     (dry_q),
    .wr_data_o (wr_right),
    .y_o       (out_right_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

/* tb/sv/tb_stereo_feedback_delay_core.sv */
module tb_stereo_feedback_delay_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W   = sfd_pkg::SAMPLE_W;
  localparam int LINE_DEPTH = sfd_pkg::LINE_DEPTH;
  localparam int ADDR_W     = sfd_pkg::ADDR_W;
  localparam int DELAY_W    = sfd_pkg::DELAY_W;
  localparam int FB_W       = sfd_pkg::FB_W;
  localparam int MIX_W      = sfd_pkg::MIX_W;
  localparam int CFG_IDX_W  = sfd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = sfd_pkg::CFG_DATA_W;
  localparam int FRAC_W     = sfd_pkg::FRAC_W;
  localparam int ROUND_HALF = sfd_pkg::ROUND_HALF;
  localparam int FB_MAX     = sfd_pkg::FB_MAX;
  localparam int UNITY      = sfd_pkg::UNITY;

  localparam int LIMIT_CYCLES = 1_500_000;
  localparam int PHASE_ITEMS  = 200;
  localparam int RAND_PHASES  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] in_left_i = '0;
  logic signed [SAMPLE_W-1:0] in_right_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [SAMPLE_W-1:0] out_left_o;
  logic signed [SAMPLE_W-1:0] out_right_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;

  stereo_feedback_delay_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_left_i  (in_left_i),
    .in_right_i (in_right_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_left_o (out_left_o),
    .out_right_o(out_right_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the block: line store, write pointer and registers.
  bit signed [SAMPLE_W-1:0] echo_line [LINE_DEPTH][2];
  logic [ADDR_W-1:0]        wr_ptr    = '0;
  logic [DELAY_W-1:0]       cur_delay = 17'd48;
  logic [FB_W-1:0]          cur_fb    = '0;
  logic [MIX_W-1:0]         cur_wet   = 17'd32768;

  frame_t frames_to_send[$];
  frame_t expected_out[$];
  frame_t next_frame;
  frame_t want;

  int  error_count  = 0;
  int  results_seen = 0;
  int  next_hold    = 250;
  int  hold_left    = 0;
  int  ready_pct    = 100;
  int  pattern_left = 0;
  int  burst_left   = 0;
  int  gap_left     = 0;
  bit  calm         = 1'b0;
  int  cycle_count  = 0;

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint signed v);
    longint signed hi;
    longint signed lo;
    hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v = hi;
    end else if (v < lo) begin
      v = lo;
    end
    return SAMPLE_W'(v);
  endfunction

  // Mixes one frame against the delayed one and feeds the echo back into the line.
  function automatic void echo_frame(input logic signed [SAMPLE_W-1:0] x_left,
                                     input logic signed [SAMPLE_W-1:0] x_right);
    longint signed fb;
    longint signed wet;
    longint signed dry;
    longint signed x;
    longint signed dl;
    logic [ADDR_W-1:0] rd;
    logic signed [SAMPLE_W-1:0] x_in [2];
    logic signed [SAMPLE_W-1:0] y_out [2];
    frame_t res;
    fb  = (cur_fb > FB_MAX) ? FB_MAX : longint'(cur_fb);
    wet = (cur_wet > UNITY) ? UNITY : longint'(cur_wet);
    dry = UNITY - wet;
    rd  = (cur_delay > LINE_DEPTH - 1) ? wr_ptr - ADDR_W'(LINE_DEPTH - 1)
                                       : wr_ptr - ADDR_W'(cur_delay);
    x_in[0] = x_left;
    x_in[1] = x_right;
    for (int ch = 0; ch < 2; ch++) begin
      x  = x_in[ch];
      dl = echo_line[rd][ch];
      y_out[ch] = clip_sample((x * dry + dl * wet + ROUND_HALF) >>> FRAC_W);
      echo_line[wr_ptr][ch] = clip_sample(x + ((dl * fb + ROUND_HALF) >>> FRAC_W));
    end
    wr_ptr = wr_ptr + 1'b1;
    res.left  = y_out[0];
    res.right = y_out[1];
    expected_out.push_back(res);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void push_frame(input logic signed [SAMPLE_W-1:0] l,
                                     input logic signed [SAMPLE_W-1:0] r);
    frame_t f;
    f.left  = l;
    f.right = r;
    frames_to_send.push_back(f);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sfd_pkg::CFG_DELAY:    cur_delay = data[DELAY_W-1:0];
      sfd_pkg::CFG_FEEDBACK: cur_fb    = data[FB_W-1:0];
      sfd_pkg::CFG_WET_MIX:  cur_wet   = data[MIX_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frames_to_send.size() != 0 || in_valid_i || expected_out.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Sender: bursts of random length separated by random gaps; in the calm phase, bursts of 1000 with no gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_left_i  <= '0;
      in_right_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        echo_frame(in_left_i, in_right_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (frames_to_send.size() != 0) begin
          next_frame = frames_to_send.pop_front();
          in_valid_i <= 1'b1;
          in_left_i  <= next_frame.left;
          in_right_i <= next_frame.right;
          if (burst_left <= 1) begin
            burst_left = calm ? 1000 : $urandom_range(1, 24);
            gap_left   = calm ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall density changes at random intervals (always ready when calm), with a long
  // hold-off every 500 results, the first after 250, so the pipeline backs up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_out.size() == 0) begin
          flag_error($sformatf("result %0d/%0d with nothing expected", out_left_o, out_right_o));
        end else begin
          want = expected_out.pop_front();
          if (out_left_o !== want.left) begin
            flag_error($sformatf("out_left expected %0d, got %0d", want.left, out_left_o));
          end
          if (out_right_o !== want.right) begin
            flag_error($sformatf("out_right expected %0d, got %0d", want.right, out_right_o));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (results_seen >= next_hold) begin
        hold_left = $urandom_range(100, 200);
        next_hold += 500;
        out_ready_i <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        pattern_left--;
        out_ready_i <= calm || ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_stereo_feedback_delay_core: done, errors");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: long delay, so every delayed read is silence.
    push_frame('0, '0);
    push_frame(S_MAX, S_MIN);
    push_frame(S_MIN, S_MAX);
    push_frame(SAMPLE_W'(-1), SAMPLE_W'(1));
    push_frame(SAMPLE_W'(1), SAMPLE_W'(-1));
    wait_drained();

    // Fully wet with the largest feedback drives the line into saturation.
    write_reg(sfd_pkg::CFG_DELAY, 17'd1);
    write_reg(sfd_pkg::CFG_FEEDBACK, CFG_DATA_W'(FB_MAX));
    write_reg(sfd_pkg::CFG_WET_MIX, CFG_DATA_W'(UNITY));
    repeat (4) push_frame(S_MAX, S_MIN);
    repeat (2) push_frame(S_MIN, S_MAX);
    wait_drained();

    // Zero delay, out-of-range gains, and a write to an unused index.
    write_reg(sfd_pkg::CFG_DELAY, 17'd0);
    write_reg(sfd_pkg::CFG_FEEDBACK, 17'h1FFFF);
    write_reg(sfd_pkg::CFG_WET_MIX, 17'h1FFFF);
    write_reg(CFG_NO_REG, 17'h1FFFF);
    push_frame(S_MAX, S_MAX);
    push_frame(S_MIN, S_MIN);
    push_frame(SAMPLE_W'(12345), SAMPLE_W'(-12345));
    push_frame('0, '0);
    wait_drained();

    // Bit 16 of the feedback write is dropped, leaving no feedback; fully dry.
    write_reg(sfd_pkg::CFG_DELAY, 17'd2);
    write_reg(sfd_pkg::CFG_FEEDBACK, 17'h10000);
    write_reg(sfd_pkg::CFG_WET_MIX, 17'd0);
    push_frame(S_MAX, S_MIN);
    push_frame(S_MIN, S_MAX);
    push_frame(SAMPLE_W'(100), SAMPLE_W'(-100));
    push_frame('0, '0);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      calm = (p == 3);
      case ($urandom_range(0, 5))
        0: write_reg(sfd_pkg::CFG_DELAY, 17'd0);
        1: write_reg(sfd_pkg::CFG_DELAY, 17'd1);
        2: write_reg(sfd_pkg::CFG_DELAY, CFG_DATA_W'($urandom_range(2, 8)));
        3: write_reg(sfd_pkg::CFG_DELAY, CFG_DATA_W'($urandom_range(9, 300)));
        4: write_reg(sfd_pkg::CFG_DELAY, CFG_DATA_W'($urandom_range(1, LINE_DEPTH - 1)));
        default: write_reg(sfd_pkg::CFG_DELAY, 17'd3);
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(sfd_pkg::CFG_FEEDBACK, 17'd0);
        1: write_reg(sfd_pkg::CFG_FEEDBACK, CFG_DATA_W'(FB_MAX));
        2: write_reg(sfd_pkg::CFG_FEEDBACK,
                     CFG_DATA_W'($urandom_range(FB_MAX + 1, 17'h1FFFF)));
        default: write_reg(sfd_pkg::CFG_FEEDBACK, CFG_DATA_W'($urandom_range(0, FB_MAX)));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(sfd_pkg::CFG_WET_MIX, 17'd0);
        1: write_reg(sfd_pkg::CFG_WET_MIX, CFG_DATA_W'(UNITY));
        2: write_reg(sfd_pkg::CFG_WET_MIX,
                     CFG_DATA_W'($urandom_range(UNITY + 1, 17'h1FFFF)));
        default: write_reg(sfd_pkg::CFG_WET_MIX, CFG_DATA_W'($urandom_range(0, UNITY)));
      endcase
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_NO_REG, CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
      end
      repeat (PHASE_ITEMS) push_frame(pick_sample(), pick_sample());
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (expected_out.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_out.size()));
    end
    if (error_count == 0) begin
      $display("tb_stereo_feedback_delay_core: done, clean");
    end else begin
      $display("tb_stereo_feedback_delay_core: done, errors");
    end
    $finish;
  end

endmodule
